// ===== rtl/core/lacb_pkg.sv =====
// Shared types and constants for the look-at camera basis block.
// Depends on nothing; every other file imports it.
package lacb_pkg;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 15;
  localparam int REM_W      = 34;
  localparam int RAD_W      = 64;
  localparam int LIM_W      = 15;

  localparam logic [LIM_W-1:0] LIMIT_RESET = 15'd16383;
  localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

  typedef logic signed [31:0] s32_t;
  typedef logic signed [15:0] s16_t;
  typedef logic [31:0] u32_t;
  typedef s32_t [2:0] vec32_t;
  typedef s16_t [2:0] vec16_t;
  typedef u32_t [2:0] uvec32_t;

endpackage

// ===== rtl/core/lacb_sqrt_cell.sv =====
// One cell of the square-root chain: settles one root bit per stage.
// Depends on lacb_pkg.
module lacb_sqrt_cell #(
  parameter int SIDE_W = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       vld_i,
  input  logic [lacb_pkg::REM_W-1:0] rem_i,
  input  lacb_pkg::u32_t             root_i,
  input  logic [lacb_pkg::RAD_W-1:0] x_i,
  input  logic [SIDE_W-1:0]          side_i,
  output logic                       vld_o,
  output logic [lacb_pkg::REM_W-1:0] rem_o,
  output lacb_pkg::u32_t             root_o,
  output logic [lacb_pkg::RAD_W-1:0] x_o,
  output logic [SIDE_W-1:0]          side_o
);
  import lacb_pkg::*;

  logic [REM_W+1:0] r4;
  logic [REM_W+1:0] trial;
  logic [REM_W+1:0] diff;
  logic             ge;

  always_comb begin
    r4    = {rem_i, x_i[RAD_W-1 -: 2]};
    trial = {2'b00, root_i, 2'b01};
    diff  = r4 - trial;
    ge    = r4 >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o  <= ge ? diff[REM_W-1:0] : r4[REM_W-1:0];
      root_o <= {root_i[30:0], ge};
      x_o    <= {x_i[RAD_W-3:0], 2'b00};
      side_o <= side_i;
    end
  end

endmodule

// ===== rtl/core/lacb_div_cell.sv =====
// One cell of the divider chain: one quotient bit for each of three lanes.
// Depends on lacb_pkg.
module lacb_div_cell #(
  parameter int SIDE_W = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  vld_i,
  input  lacb_pkg::u32_t        n_i,
  input  lacb_pkg::uvec32_t     rem_i,
  input  logic [2:0][14:0]      lo_i,
  input  logic [SIDE_W-1:0]     side_i,
  output logic                  vld_o,
  output lacb_pkg::u32_t        n_o,
  output lacb_pkg::uvec32_t     rem_o,
  output logic [2:0][14:0]      lo_o,
  output logic [SIDE_W-1:0]     side_o
);
  import lacb_pkg::*;

  logic [2:0][32:0] r2;
  logic [2:0][32:0] diff;
  logic [2:0]       ge;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      r2[i]   = {rem_i[i], lo_i[i][14]};
      diff[i] = r2[i] - {1'b0, n_i};
      ge[i]   = r2[i] >= {1'b0, n_i};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_o    <= n_i;
      side_o <= side_i;
      for (int i = 0; i < 3; i++) begin
        rem_o[i] <= ge[i] ? diff[i][31:0] : r2[i][31:0];
        lo_o[i]  <= {lo_i[i][13:0], ge[i]};
      end
    end
  end

endmodule

// ===== rtl/core/lacb_unit.sv =====
// Scales a three-component vector to unit length in Q2.14 with a pipelined
// square-root chain and divider chain. Depends on lacb_pkg and both cells.
module lacb_unit #(
  parameter int TAG_W = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               vld_i,
  input  lacb_pkg::vec32_t   c_i,
  input  logic [TAG_W-1:0]   tag_i,
  output logic               vld_o,
  output lacb_pkg::vec16_t   u_o,
  output logic               nz_o,
  output logic [TAG_W-1:0]   tag_o
);
  import lacb_pkg::*;

  localparam int SQ_SIDE  = TAG_W + 96 + 4;
  localparam int DV_SIDE  = TAG_W + 4;

  logic            a_vld, b_vld, c_vld, d_vld, e_vld;
  uvec32_t         a_mag, b_mag;
  logic [2:0]      a_sgn, b_sgn, c_sgn, d_sgn;
  u32_t            a_max;
  logic            b_nz, c_nz, d_nz;
  logic [TAG_W-1:0] a_tag, b_tag, c_tag, d_tag;
  logic [2:0][63:0] c_sq;
  uvec32_t         c_mag, d_mag;
  logic [RAD_W-1:0] d_sum;

  logic [4:0] msb;
  logic [4:0] shamt;

  always_comb begin
    msb = '0;
    for (int i = 0; i < 31; i++) begin
      if (a_max[i]) begin
        msb = 5'(i);
      end
    end
    shamt = (a_max[31:30] != 2'b00 || a_max == '0) ? 5'd0 : 5'(5'd30 - msb);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
      d_vld <= 1'b0;
    end else if (en) begin
      a_vld <= vld_i;
      b_vld <= a_vld;
      c_vld <= b_vld;
      d_vld <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a_sgn[i] <= c_i[i][31];
        a_mag[i] <= c_i[i][31] ? u32_t'(-c_i[i]) : u32_t'(c_i[i]);
      end
      begin
        u32_t m0, m1, m2, mm;
        m0 = c_i[0][31] ? u32_t'(-c_i[0]) : u32_t'(c_i[0]);
        m1 = c_i[1][31] ? u32_t'(-c_i[1]) : u32_t'(c_i[1]);
        m2 = c_i[2][31] ? u32_t'(-c_i[2]) : u32_t'(c_i[2]);
        mm = (m0 > m1) ? m0 : m1;
        a_max <= (mm > m2) ? mm : m2;
      end
      a_tag <= tag_i;

      for (int i = 0; i < 3; i++) begin
        b_mag[i] <= a_mag[i] << shamt;
      end
      b_sgn <= a_sgn;
      b_nz  <= a_max != '0;
      b_tag <= a_tag;

      for (int i = 0; i < 3; i++) begin
        c_sq[i] <= 64'(b_mag[i]) * 64'(b_mag[i]);
      end
      c_mag <= b_mag;
      c_sgn <= b_sgn;
      c_nz  <= b_nz;
      c_tag <= b_tag;

      d_sum <= c_sq[0] + c_sq[1] + c_sq[2];
      d_mag <= c_mag;
      d_sgn <= c_sgn;
      d_nz  <= c_nz;
      d_tag <= c_tag;
    end
  end

  logic [SQRT_STEPS:0]             sq_vld;
  logic [SQRT_STEPS:0][REM_W-1:0]  sq_rem;
  u32_t [SQRT_STEPS:0]             sq_root;
  logic [SQRT_STEPS:0][RAD_W-1:0]  sq_x;
  logic [SQRT_STEPS:0][SQ_SIDE-1:0] sq_side;

  assign sq_vld[0]  = d_vld;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_x[0]    = d_sum;
  assign sq_side[0] = {d_tag, d_mag, d_sgn, d_nz};

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    lacb_sqrt_cell #(.SIDE_W(SQ_SIDE)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .vld_i  (sq_vld[g]),
      .rem_i  (sq_rem[g]),
      .root_i (sq_root[g]),
      .x_i    (sq_x[g]),
      .side_i (sq_side[g]),
      .vld_o  (sq_vld[g+1]),
      .rem_o  (sq_rem[g+1]),
      .root_o (sq_root[g+1]),
      .x_o    (sq_x[g+1]),
      .side_o (sq_side[g+1])
    );
  end

  logic [TAG_W-1:0] s_tag;
  uvec32_t          s_mag;
  logic [2:0]       s_sgn;
  logic             s_nz;
  u32_t             s_n;

  assign {s_tag, s_mag, s_sgn, s_nz} = sq_side[SQRT_STEPS];
  assign s_n = sq_root[SQRT_STEPS];

  u32_t             e_n;
  uvec32_t          e_rem;
  logic [2:0][14:0] e_lo;
  logic [DV_SIDE-1:0] e_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else if (en) begin
      e_vld <= sq_vld[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        logic [45:0] num;
        num = {s_mag[i], 14'd0} + 46'(s_n >> 1);
        e_rem[i] <= {1'b0, num[45:15]};
        e_lo[i]  <= num[14:0];
      end
      e_n    <= s_n;
      e_side <= {s_tag, s_sgn, s_nz};
    end
  end

  logic [DIV_STEPS:0]              dv_vld;
  u32_t [DIV_STEPS:0]              dv_n;
  uvec32_t [DIV_STEPS:0]           dv_rem;
  logic [DIV_STEPS:0][2:0][14:0]   dv_lo;
  logic [DIV_STEPS:0][DV_SIDE-1:0] dv_side;

  assign dv_vld[0]  = e_vld;
  assign dv_n[0]    = e_n;
  assign dv_rem[0]  = e_rem;
  assign dv_lo[0]   = e_lo;
  assign dv_side[0] = e_side;

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    lacb_div_cell #(.SIDE_W(DV_SIDE)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .vld_i  (dv_vld[g]),
      .n_i    (dv_n[g]),
      .rem_i  (dv_rem[g]),
      .lo_i   (dv_lo[g]),
      .side_i (dv_side[g]),
      .vld_o  (dv_vld[g+1]),
      .n_o    (dv_n[g+1]),
      .rem_o  (dv_rem[g+1]),
      .lo_o   (dv_lo[g+1]),
      .side_o (dv_side[g+1])
    );
  end

  logic [TAG_W-1:0] q_tag;
  logic [2:0]       q_sgn;
  logic             q_nz;

  assign {q_tag, q_sgn, q_nz} = dv_side[DIV_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= dv_vld[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        u_o[i] <= q_sgn[i] ? -s16_t'({1'b0, dv_lo[DIV_STEPS][i]})
                           : s16_t'({1'b0, dv_lo[DIV_STEPS][i]});
      end
      nz_o  <= q_nz;
      tag_o <= q_tag;
    end
  end

endmodule

// ===== rtl/core/look_at_camera_basis.sv =====
// Throughput: one direction vector per cycle; the whole pipeline advances
// together and holds only while a finished result waits at the output.
// Reset clears all valid flags and loads the near-parallel limit with 16383.
// Two scaling units, each a 32-cell root chain and a 15-cell divider chain.
module look_at_camera_basis (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [14:0]           cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  lacb_pkg::s32_t        dir_x,
  input  lacb_pkg::s32_t        dir_y,
  input  lacb_pkg::s32_t        dir_z,
  output logic                  out_valid,
  input  logic                  out_ready,
  output lacb_pkg::s16_t        right_x,
  output lacb_pkg::s16_t        right_y,
  output lacb_pkg::s16_t        right_z,
  output lacb_pkg::s16_t        upward_x,
  output lacb_pkg::s16_t        upward_y,
  output lacb_pkg::s16_t        upward_z,
  output lacb_pkg::s16_t        forward_x,
  output lacb_pkg::s16_t        forward_y,
  output lacb_pkg::s16_t        forward_z,
  output logic                  used_alternate_up,
  output logic                  valid_res
);
  import lacb_pkg::*;

  logic            en;
  logic [LIM_W-1:0] limit;

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (cfg_valid) begin
      limit <= cfg_data;
    end
  end

  logic     f_vld, f_nz, f_tag;
  vec16_t   f;

  lacb_unit #(.TAG_W(1)) u_fwd (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .vld_i (in_valid && in_ready),
    .c_i   ({dir_z, dir_y, dir_x}),
    .tag_i (1'b1),
    .vld_o (f_vld),
    .u_o   (f),
    .nz_o  (f_nz),
    .tag_o (f_tag)
  );

  logic     g_vld, g_alt, g_nz;
  vec16_t   g_f;
  vec32_t   g_cr;
  logic [15:0] afy;

  assign afy = f[1][15] ? 16'(-f[1]) : 16'(f[1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      g_vld <= 1'b0;
    end else if (en) begin
      g_vld <= f_vld && f_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_f   <= f;
      g_nz  <= f_nz;
      g_alt <= afy > {1'b0, limit};
      if (afy > {1'b0, limit}) begin
        g_cr[0] <= 32'(-f[1]);
        g_cr[1] <= 32'(f[0]);
        g_cr[2] <= '0;
      end else begin
        g_cr[0] <= 32'(-f[2]);
        g_cr[1] <= '0;
        g_cr[2] <= 32'(f[0]);
      end
    end
  end

  localparam int TAG2_W = 48 + 2;

  logic              r_vld, r_nz;
  vec16_t            r;
  logic [TAG2_W-1:0] r_tag;

  lacb_unit #(.TAG_W(TAG2_W)) u_right (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .vld_i (g_vld),
    .c_i   (g_cr),
    .tag_i ({g_f, g_alt, g_nz}),
    .vld_o (r_vld),
    .u_o   (r),
    .nz_o  (r_nz),
    .tag_o (r_tag)
  );

  vec16_t rf;
  logic   r_alt, r_fnz;

  assign {rf, r_alt, r_fnz} = r_tag;

  logic              h_vld, h_alt, h_fnz, h_rnz;
  vec16_t            h_r, h_f;
  s32_t [5:0]        h_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      h_vld <= 1'b0;
    end else if (en) begin
      h_vld <= r_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_p[0] <= 32'(r[1]) * 32'(rf[2]);
      h_p[1] <= 32'(r[2]) * 32'(rf[1]);
      h_p[2] <= 32'(r[2]) * 32'(rf[0]);
      h_p[3] <= 32'(r[0]) * 32'(rf[2]);
      h_p[4] <= 32'(r[0]) * 32'(rf[1]);
      h_p[5] <= 32'(r[1]) * 32'(rf[0]);
      h_r    <= r;
      h_f    <= rf;
      h_alt  <= r_alt;
      h_fnz  <= r_fnz;
      h_rnz  <= r_nz;
    end
  end

  function automatic s16_t round_clamp(input s32_t p);
    s32_t t;
    t = (p + 32'sd8192) >>> 14;
    if (t > 32'(ONE_Q14)) begin
      return ONE_Q14;
    end else if (t < -32'(ONE_Q14)) begin
      return -ONE_Q14;
    end
    return t[15:0];
  endfunction

  vec16_t up;

  assign up[0] = round_clamp(h_p[0] - h_p[1]);
  assign up[1] = round_clamp(h_p[2] - h_p[3]);
  assign up[2] = round_clamp(h_p[4] - h_p[5]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= h_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      forward_x         <= h_fnz ? h_f[0] : '0;
      forward_y         <= h_fnz ? h_f[1] : '0;
      forward_z         <= h_fnz ? h_f[2] : '0;
      right_x           <= (h_fnz && h_rnz) ? h_r[0] : '0;
      right_y           <= (h_fnz && h_rnz) ? h_r[1] : '0;
      right_z           <= (h_fnz && h_rnz) ? h_r[2] : '0;
      upward_x          <= (h_fnz && h_rnz) ? up[0] : '0;
      upward_y          <= (h_fnz && h_rnz) ? up[1] : '0;
      upward_z          <= (h_fnz && h_rnz) ? up[2] : '0;
      used_alternate_up <= h_fnz && h_alt;
      valid_res         <= h_fnz;
    end
  end

endmodule

// ===== bench/tb_look_at_camera_basis.sv =====
// Testbench for look_at_camera_basis: drives direction vectors under several idle and
// stall patterns and register settings, and checks every basis matrix against a predictor.
// Depends on rtl/core/lacb_pkg.sv and rtl/core/look_at_camera_basis.sv.
module tb_look_at_camera_basis;
  timeunit 1ns;
  timeprecision 1ps;
  import lacb_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 130;

  typedef struct {
    s16_t rgt [3];
    s16_t upw [3];
    s16_t fwd [3];
    logic alt;
    logic ok;
  } basis_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [14:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  s32_t dir_x = '0, dir_y = '0, dir_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  s16_t right_x, right_y, right_z, upward_x, upward_y, upward_z;
  s16_t forward_x, forward_y, forward_z;
  logic used_alternate_up, valid_res;

  basis_t pending_bases[$];
  logic [14:0] limit_q = LIMIT_RESET;
  int errors = 0;
  int cycles = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;

  look_at_camera_basis dut (.*);

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic bit to_unit(input longint c [3], output longint o [3]);
    longint unsigned a [3];
    longint unsigned mx = 0, s = 0, n, q;
    int k = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = (c[i] < 0) ? -c[i] : c[i];
      if (a[i] > mx) mx = a[i];
    end
    for (int i = 0; i < 3; i++) o[i] = 0;
    if (mx == 0) return 0;
    while (k < 30 && (mx << k) < (64'd1 << 30)) k++;
    for (int i = 0; i < 3; i++) begin
      a[i] <<= k;
      s += a[i] * a[i];
    end
    n = int_sqrt(s);
    for (int i = 0; i < 3; i++) begin
      q = (a[i] * 16384 + (n >> 1)) / n;
      o[i] = (c[i] < 0) ? -longint'(q) : longint'(q);
    end
    return 1;
  endfunction

  function automatic longint round_q14(longint p);
    longint r = (p + 8192) >>> 14;
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r;
  endfunction

  function automatic basis_t predict_basis(s32_t x, s32_t y, s32_t z);
    basis_t b;
    longint v [3], f [3], cr [3], r [3], u [3];
    longint afy;
    v[0] = x; v[1] = y; v[2] = z;
    b.alt = 0;
    b.ok = 0;
    for (int i = 0; i < 3; i++) begin
      b.rgt[i] = 0; b.upw[i] = 0; b.fwd[i] = 0;
    end
    if (to_unit(v, f)) begin
      afy = (f[1] < 0) ? -f[1] : f[1];
      b.alt = (afy > longint'(limit_q));
      if (!b.alt) begin
        cr[0] = -f[2]; cr[1] = 0; cr[2] = f[0];
      end else begin
        cr[0] = -f[1]; cr[1] = f[0]; cr[2] = 0;
      end
      if (to_unit(cr, r)) begin
        u[0] = round_q14(r[1] * f[2] - r[2] * f[1]);
        u[1] = round_q14(r[2] * f[0] - r[0] * f[2]);
        u[2] = round_q14(r[0] * f[1] - r[1] * f[0]);
      end else begin
        u[0] = 0; u[1] = 0; u[2] = 0;
      end
      for (int i = 0; i < 3; i++) begin
        b.rgt[i] = s16_t'(r[i]);
        b.upw[i] = s16_t'(u[i]);
        b.fwd[i] = s16_t'(f[i]);
      end
      b.ok = 1;
    end
    return b;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("[%0t] %s: got %0d, expected %0d", $realtime, field, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    basis_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_bases.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        e = pending_bases.pop_front();
        if (right_x !== e.rgt[0]) report_mismatch("right_x", right_x, e.rgt[0]);
        if (right_y !== e.rgt[1]) report_mismatch("right_y", right_y, e.rgt[1]);
        if (right_z !== e.rgt[2]) report_mismatch("right_z", right_z, e.rgt[2]);
        if (upward_x !== e.upw[0]) report_mismatch("upward_x", upward_x, e.upw[0]);
        if (upward_y !== e.upw[1]) report_mismatch("upward_y", upward_y, e.upw[1]);
        if (upward_z !== e.upw[2]) report_mismatch("upward_z", upward_z, e.upw[2]);
        if (forward_x !== e.fwd[0]) report_mismatch("forward_x", forward_x, e.fwd[0]);
        if (forward_y !== e.fwd[1]) report_mismatch("forward_y", forward_y, e.fwd[1]);
        if (forward_z !== e.fwd[2]) report_mismatch("forward_z", forward_z, e.fwd[2]);
        if (used_alternate_up !== e.alt)
          report_mismatch("used_alternate_up", used_alternate_up, e.alt);
        if (valid_res !== e.ok) report_mismatch("valid_res", valid_res, e.ok);
      end
    end
  end

  task automatic send_dir(s32_t x, s32_t y, s32_t z);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    dir_x <= x;
    dir_y <= y;
    dir_z <= z;
    do @(posedge clk); while (!in_ready);
    pending_bases.push_back(predict_basis(x, y, z));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_bases.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(logic [14:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    limit_q = v;
  endtask

  function automatic s32_t rand_component(int mode);
    s32_t c;
    case (mode)
      0: c = $urandom;
      1: c = $signed($urandom_range(200)) - 100;
      2: c = $signed($urandom) >>> $urandom_range(31);
      default: c = $signed($urandom_range(8000)) - 4000;
    endcase
    return c;
  endfunction

  task automatic send_random_dir();
    int mode = $urandom_range(9);
    s32_t x, y, z;
    if (mode == 0) begin
      x = 0; y = 0; z = 0;
    end else if (mode <= 3) begin
      x = rand_component(3) >>> $urandom_range(8);
      z = rand_component(3) >>> $urandom_range(8);
      y = ($urandom_range(1) ? 32'sd1 : -32'sd1) * ($urandom_range(32'h7fff_0000) + 1);
    end else begin
      x = rand_component(mode % 3);
      y = rand_component($urandom_range(2));
      z = rand_component($urandom_range(2));
    end
    send_dir(x, y, z);
  endtask

  task automatic test_axes_and_zero();
    send_dir(0, 0, 0);
    send_dir(32'sh10000, 0, 0);
    send_dir(-32'sh10000, 0, 0);
    send_dir(0, 0, 32'sh10000);
    send_dir(0, 0, -32'sh10000);
    send_dir(0, 32'sh10000, 0);
    send_dir(0, -32'sh10000, 0);
    send_dir(1, 1, 1);
    send_dir(0, 0, -1);
  endtask

  task automatic test_extremes();
    send_dir(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_dir(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_dir(32'h8000_0000, 0, 32'h7fff_ffff);
    send_dir(-1, 32'h7fff_ffff, 1);
    send_dir(32'h7fff_ffff, 32'h8000_0000, -1);
    send_dir(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555);
  endtask

  task automatic test_near_parallel();
    write_limit(15'd16384);
    send_dir(0, 32'sh10000, 0);
    send_dir(0, -32'sh7fff_ffff, 0);
    send_dir(1, 32'sh7fff_ffff, 0);
    write_limit(15'd0);
    send_dir(32'sh10000, 1, 0);
    send_dir(32'sh10000, 0, 5);
    send_dir(3, -32'sh10000, 7);
    write_limit(15'h7fff);
    send_dir(0, 32'sh10000, 0);
    send_dir(1, 32'sh10000, 1);
    write_limit(LIMIT_RESET);
    send_dir(0, 32'sh10000, 0);
    send_dir(2, 32'sh7fff_ffff, -3);
  endtask

  task automatic test_random_phases();
    int idle_set [4] = '{0, 69, 0, 16};
    int stall_set [4] = '{0, 0, 69, 16};
    logic [14:0] limit_set [4];
    limit_set[0] = 15'(16000 + $urandom_range(384));
    limit_set[1] = 15'($urandom_range(16384));
    limit_set[2] = 15'd16384;
    limit_set[3] = LIMIT_RESET;
    for (int p = 0; p < 4; p++) begin
      write_limit(limit_set[p]);
      idle_pct = idle_set[p];
      stall_pct = stall_set[p];
      repeat (140) send_random_dir();
    end
    idle_pct = 0;
    stall_pct = 0;
  endtask

  task automatic test_backpressure();
    write_limit(15'($urandom_range(32767)));
    hold_cycles = 400;
    repeat (120) send_random_dir();
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_axes_and_zero();
    test_extremes();
    test_near_parallel();
    test_random_phases();
    test_backpressure();
    wait_drained();
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
